// ===== rtl/triangle_window_max_sum_defines.svh =====
// Assertion macros shared by the triangle window maximum-sum design.
// No dependencies; included by the modules that carry assertions.
`ifndef TRIANGLE_WINDOW_MAX_SUM_DEFINES_SVH
`define TRIANGLE_WINDOW_MAX_SUM_DEFINES_SVH

// Property that must hold in every cycle outside of reset.
`define TWMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that forces a consequence in the next cycle.
`define TWMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/twms_pkg.sv =====
// Shared types and constants for the triangle window maximum-sum design.
// No dependencies.
package twms_pkg;

  localparam int MaxRowsDef   = 64;
  localparam int ValueBitsDef = 32;
  localparam int SumBits      = 44;
  localparam int CfgBits      = 7;
  localparam int CellBits     = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LVL_H,
    ST_LVL_B,
    ST_LVL_C,
    ST_LVL_W,
    ST_SUM_R,
    ST_SUM_A,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_HERE,
    RD_BELOW,
    RD_BELOW1
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    clr_loop;
    logic    set_s2;
    logic    inc_s;
    logic    adv_cell;
    rd_sel_e rd_sel;
    logic    take_first;
    logic    take_more;
    logic    wr_max;
    logic    clr_acc;
    logic    add_acc;
  } dp_cmd_t;

  typedef struct packed {
    logic load_last;
    logic win_gt_rows;
    logic win_one;
    logic col_last;
    logic row_last_lvl;
    logic lvl_last;
    logic row_last_sum;
  } dp_sts_t;

endpackage

// ===== rtl/triangle_window_max_sum.sv =====
// Loading: one word per cycle while busy is low. After the last word of a grid, one
// level pass per size step from 2 to k reads three cells and writes one per apex (LVL_H,
// LVL_B, LVL_C, LVL_W), then the sum pass reads and adds each apex (SUM_R, SUM_A), and
// DONE shows the result. The result strobe lasts one cycle; the receiver cannot stall it.
// Reset clears the controller, fill count, sum and registers (row_count = window_size = 1);
// the grid memory is not cleared.
module triangle_window_max_sum #(
  parameter int MAX_ROWS   = twms_pkg::MaxRowsDef,
  parameter int VALUE_BITS = twms_pkg::ValueBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [twms_pkg::CellBits-1:0] cell_value_i,
  output logic                          done_o,
  output logic [twms_pkg::SumBits-1:0]  max_sum_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [twms_pkg::CfgBits-1:0] row_count_q, window_size_q;
  logic                         cfg_we;
  twms_pkg::dp_cmd_t            cmd;
  twms_pkg::dp_sts_t            sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q   <= twms_pkg::CfgBits'(1);
      window_size_q <= twms_pkg::CfgBits'(1);
    end else if (cfg_we) begin
      if (paddr[2]) begin
        window_size_q <= pwdata[twms_pkg::CfgBits-1:0];
      end else begin
        row_count_q <= pwdata[twms_pkg::CfgBits-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? 32'(window_size_q) : 32'(row_count_q);

  twms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  twms_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .row_count_i  (row_count_q),
    .window_size_i(window_size_q),
    .cell_value_i (cell_value_i),
    .max_sum_o    (max_sum_o)
  );

endmodule

// ===== rtl/twms_datapath.sv =====
// Datapath: grid memory, loop counters, address generation, max and sum.
// Depends on twms_pkg.
module twms_datapath #(
  parameter int MAX_ROWS   = twms_pkg::MaxRowsDef,
  parameter int VALUE_BITS = twms_pkg::ValueBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  twms_pkg::dp_cmd_t             cmd_i,
  output twms_pkg::dp_sts_t             sts_o,
  input  logic [twms_pkg::CfgBits-1:0]  row_count_i,
  input  logic [twms_pkg::CfgBits-1:0]  window_size_i,
  input  logic [twms_pkg::CellBits-1:0] cell_value_i,
  output logic [twms_pkg::SumBits-1:0]  max_sum_o
);

  localparam int Depth = MAX_ROWS * (MAX_ROWS + 1) / 2;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int EW    = (RW > twms_pkg::CfgBits) ? RW : twms_pkg::CfgBits;
  localparam int PW    = 2 * EW + 1;

  logic [VALUE_BITS-1:0] mem [Depth];
  logic [VALUE_BITS-1:0] rdata_q;
  logic [VALUE_BITS-1:0] max_q, max_d, wr_val;

  logic [CW-1:0] load_cnt_q, load_cnt_d;
  logic [EW-1:0] i_q, i_d, j_q, j_d, s_q, s_d;
  logic [AW-1:0] base_q, base_d;
  logic [twms_pkg::SumBits-1:0] acc_q, acc_d;

  logic [EW-1:0] row_cfg, win_cfg, rows_eff, win_eff;
  logic [PW-1:0] tri_prod;
  logic [CW-1:0] total;
  logic [AW-1:0] here, below, below1, raddr, waddr;
  logic          we;

  // Effective row count and window size after zero and range fixups.
  always_comb begin
    row_cfg  = EW'(row_count_i);
    win_cfg  = EW'(window_size_i);
    rows_eff = (row_cfg == '0) ? EW'(1) :
               ((row_cfg > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : row_cfg);
    win_eff  = (win_cfg == '0) ? EW'(1) : win_cfg;
    tri_prod = PW'(rows_eff) * (PW'(rows_eff) + PW'(1));
    total    = tri_prod[CW:1];
  end

  always_comb begin
    here   = base_q + AW'(j_q);
    below  = here + AW'(i_q) + AW'(1);
    below1 = below + AW'(1);
    unique case (cmd_i.rd_sel)
      twms_pkg::RD_BELOW:  raddr = below;
      twms_pkg::RD_BELOW1: raddr = below1;
      default:             raddr = here;
    endcase
  end

  always_comb begin
    wr_val = (rdata_q > max_q) ? rdata_q : max_q;
    max_d  = max_q;
    if (cmd_i.take_first) begin
      max_d = rdata_q;
    end else if (cmd_i.take_more) begin
      max_d = wr_val;
    end
  end

  always_comb begin
    sts_o.load_last    = ({1'b0, load_cnt_q} + (CW + 1)'(1)) >= {1'b0, total};
    sts_o.win_gt_rows  = win_eff > rows_eff;
    sts_o.win_one      = win_eff == EW'(1);
    sts_o.col_last     = j_q == i_q;
    sts_o.row_last_lvl = ({1'b0, i_q} + {1'b0, s_q}) == {1'b0, rows_eff};
    sts_o.lvl_last     = s_q == win_eff;
    sts_o.row_last_sum = ({1'b0, i_q} + {1'b0, win_eff}) == {1'b0, rows_eff};
  end

  always_comb begin
    load_cnt_d = load_cnt_q;
    if (cmd_i.load) begin
      load_cnt_d = sts_o.load_last ? '0 : load_cnt_q + CW'(1);
    end
    i_d    = i_q;
    j_d    = j_q;
    base_d = base_q;
    if (cmd_i.clr_loop) begin
      i_d    = '0;
      j_d    = '0;
      base_d = '0;
    end else if (cmd_i.adv_cell) begin
      if (sts_o.col_last) begin
        i_d    = i_q + EW'(1);
        j_d    = '0;
        base_d = base_q + AW'(i_q) + AW'(1);
      end else begin
        j_d = j_q + EW'(1);
      end
    end
    s_d = s_q;
    if (cmd_i.set_s2) begin
      s_d = EW'(2);
    end else if (cmd_i.inc_s) begin
      s_d = s_q + EW'(1);
    end
    acc_d = acc_q;
    if (cmd_i.clr_acc) begin
      acc_d = '0;
    end else if (cmd_i.add_acc) begin
      acc_d = acc_q + twms_pkg::SumBits'(rdata_q);
    end
  end

  // Loading writes at the fill position; only positions inside the table are stored.
  assign we    = (cmd_i.load && ({1'b0, load_cnt_q} < (CW + 1)'(Depth))) || cmd_i.wr_max;
  assign waddr = cmd_i.load ? AW'(load_cnt_q) : here;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= cmd_i.load ? cell_value_i[VALUE_BITS-1:0] : wr_val;
    end
    rdata_q <= mem[raddr];
    max_q   <= max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      s_q        <= '0;
      base_q     <= '0;
      acc_q      <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
      i_q        <= i_d;
      j_q        <= j_d;
      s_q        <= s_d;
      base_q     <= base_d;
      acc_q      <= acc_d;
    end
  end

  assign max_sum_o = acc_q;

endmodule

// ===== rtl/twms_ctrl.sv =====
// Controller: sequences loading, the per-level max passes and the sum pass.
// Depends on twms_pkg and triangle_window_max_sum_defines.svh.
`include "triangle_window_max_sum_defines.svh"

module twms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  twms_pkg::dp_sts_t sts_i,
  output twms_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  twms_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      twms_pkg::ST_IDLE: begin
        if (start_i && sts_i.load_last) begin
          if (sts_i.win_gt_rows) begin
            state_d = twms_pkg::ST_DONE;
          end else if (sts_i.win_one) begin
            state_d = twms_pkg::ST_SUM_R;
          end else begin
            state_d = twms_pkg::ST_LVL_H;
          end
        end
      end
      twms_pkg::ST_LVL_H: state_d = twms_pkg::ST_LVL_B;
      twms_pkg::ST_LVL_B: state_d = twms_pkg::ST_LVL_C;
      twms_pkg::ST_LVL_C: state_d = twms_pkg::ST_LVL_W;
      twms_pkg::ST_LVL_W: begin
        if (sts_i.col_last && sts_i.row_last_lvl && sts_i.lvl_last) begin
          state_d = twms_pkg::ST_SUM_R;
        end else begin
          state_d = twms_pkg::ST_LVL_H;
        end
      end
      twms_pkg::ST_SUM_R: state_d = twms_pkg::ST_SUM_A;
      twms_pkg::ST_SUM_A: begin
        if (sts_i.col_last && sts_i.row_last_sum) begin
          state_d = twms_pkg::ST_DONE;
        end else begin
          state_d = twms_pkg::ST_SUM_R;
        end
      end
      twms_pkg::ST_DONE: state_d = twms_pkg::ST_IDLE;
      default: state_d = twms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = twms_pkg::RD_HERE;
    unique case (state_q)
      twms_pkg::ST_IDLE: begin
        cmd_o.load = start_i;
        if (start_i && sts_i.load_last) begin
          cmd_o.clr_acc  = 1'b1;
          cmd_o.clr_loop = 1'b1;
          cmd_o.set_s2   = 1'b1;
        end
      end
      twms_pkg::ST_LVL_B: begin
        cmd_o.rd_sel     = twms_pkg::RD_BELOW;
        cmd_o.take_first = 1'b1;
      end
      twms_pkg::ST_LVL_C: begin
        cmd_o.rd_sel    = twms_pkg::RD_BELOW1;
        cmd_o.take_more = 1'b1;
      end
      twms_pkg::ST_LVL_W: begin
        cmd_o.wr_max = 1'b1;
        if (sts_i.col_last && sts_i.row_last_lvl) begin
          // End of a level: restart at the apex, either for the next size or the sum.
          cmd_o.clr_loop = 1'b1;
          cmd_o.inc_s    = !sts_i.lvl_last;
        end else begin
          cmd_o.adv_cell = 1'b1;
        end
      end
      twms_pkg::ST_SUM_A: begin
        cmd_o.add_acc  = 1'b1;
        cmd_o.adv_cell = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy_o = state_q != twms_pkg::ST_IDLE;
  assign done_o = state_q == twms_pkg::ST_DONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TWMS_ASSERT_NEXT(a_done_to_idle, state_q == twms_pkg::ST_DONE, state_q == twms_pkg::ST_IDLE, "result word not followed by idle")
  `TWMS_ASSERT(a_write_after_reads, (state_q != twms_pkg::ST_LVL_W) || ($past(state_q) == twms_pkg::ST_LVL_C), "max write without its three reads")
  `TWMS_ASSERT_NEXT(a_oversize_window, cmd_o.load && sts_i.load_last && sts_i.win_gt_rows, state_q == twms_pkg::ST_DONE, "oversize window did not report at once")

endmodule

// ===== bench/triangle_window_max_sum_test.sv =====
// Self-checking bench for triangle_window_max_sum: loads triangular grids over the
// command port, predicts each window maximum sum and compares the result words.
// Depends on twms_pkg and the triangle_window_max_sum RTL.
module triangle_window_max_sum_test;

  localparam int MaxRows = twms_pkg::MaxRowsDef;
  localparam int Depth   = MaxRows * (MaxRows + 1) / 2;
  localparam logic [2:0] AddrRows = 3'd0;
  localparam logic [2:0] AddrWin  = 3'd4;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [twms_pkg::CellBits-1:0] cell_value_i = '0;
  logic                          done_o;
  logic [twms_pkg::SumBits-1:0]  max_sum_o;
  logic                          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]                    paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  triangle_window_max_sum uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: grid copy, fill count and register copies.
  logic [twms_pkg::CellBits-1:0] grid_copy[Depth];
  int unsigned                   fill_count;
  logic [twms_pkg::CfgBits-1:0]  rows_reg, win_reg;

  logic [twms_pkg::CellBits-1:0] pending_words[$];
  logic [twms_pkg::SumBits-1:0]  expected_sums[$];
  logic                          calm = 1'b0;
  int                            failures = 0;

  function automatic logic [twms_pkg::SumBits-1:0] window_max_sum(int rows, int win);
    logic [twms_pkg::CellBits-1:0] lvl[Depth];
    logic [twms_pkg::SumBits-1:0]  acc;
    int h, b;
    lvl = grid_copy;
    acc = '0;
    if (win > rows) return '0;
    for (int s = 2; s <= win; s++)
      for (int i = 0; i + s <= rows; i++)
        for (int j = 0; j <= i; j++) begin
          h = i * (i + 1) / 2 + j;
          b = (i + 1) * (i + 2) / 2 + j;
          if (lvl[b] > lvl[h]) lvl[h] = lvl[b];
          if (lvl[b + 1] > lvl[h]) lvl[h] = lvl[b + 1];
        end
    for (int i = 0; i + win <= rows; i++)
      for (int j = 0; j <= i; j++)
        acc = acc + twms_pkg::SumBits'(lvl[i * (i + 1) / 2 + j]);
    return acc;
  endfunction

  // Called for each accepted word; queues the grid sum when the grid completes.
  task automatic take_word(logic [twms_pkg::CellBits-1:0] w);
    int rows, win, total;
    rows = rows_reg;
    win = win_reg;
    if (rows == 0) rows = 1;
    if (rows > MaxRows) rows = MaxRows;
    if (win == 0) win = 1;
    total = rows * (rows + 1) / 2;
    if (fill_count < Depth) grid_copy[fill_count] = w;
    fill_count++;
    if (fill_count >= total) begin
      fill_count = 0;
      expected_sums.push_back(window_max_sum(rows, win));
    end
  endtask

  // Driver: one word per handshake, idling at random unless calm.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        take_word(cell_value_i);
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
        start <= 1'b1;
        cell_value_i <= pending_words[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    logic [twms_pkg::SumBits-1:0] want;
    if (rst_ni && done_o) begin
      if (expected_sums.size() == 0) begin
        $error("max_sum: unexpected result %0d", max_sum_o);
        failures++;
      end else begin
        want = expected_sums.pop_front();
        if (max_sum_o !== want) begin
          $error("max_sum: expected %0d, actual %0d", want, max_sum_o);
          failures++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || start) @(posedge clk_i);
    while (expected_sums.size() > 0) @(posedge clk_i);
    // A grid with no result can leave nothing pending; allow trailing work to settle.
    repeat (20) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrRows) rows_reg = data[twms_pkg::CfgBits-1:0];
    else win_reg = data[twms_pkg::CfgBits-1:0];
  endtask

  function automatic logic [twms_pkg::CellBits-1:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  task automatic run_grids(int rows, int win, int grids);
    int n;
    n = (rows == 0 ? 1 : (rows > MaxRows ? MaxRows : rows));
    write_reg(AddrRows, 32'(rows));
    write_reg(AddrWin, 32'(win));
    for (int g = 0; g < grids; g++)
      for (int c = 0; c < n * (n + 1) / 2; c++) pending_words.push_back(rand_word());
    wait_drained();
  endtask

  int sent;

  initial begin
    fill_count = 0;
    rows_reg = 1;
    win_reg = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: reset defaults, extreme values, zero registers, window above rows.
    pending_words.push_back('0);
    pending_words.push_back('1);
    wait_drained();
    write_reg(AddrRows, 32'd3);
    write_reg(AddrWin, 32'd2);
    foreach (grid_copy[k]) if (k < 6) pending_words.push_back(k[0] ? '1 : 32'h8000_0001);
    wait_drained();
    run_grids(0, 0, 2);
    run_grids(2, 5, 2);
    run_grids(3, 3, 1);
    run_grids(1, 64, 1);
    // A mid-grid register change: shrink rows after part of a grid has loaded.
    write_reg(AddrRows, 32'd4);
    write_reg(AddrWin, 32'd1);
    for (int c = 0; c < 7; c++) pending_words.push_back(rand_word());
    wait_drained();
    write_reg(AddrRows, 32'd2);
    pending_words.push_back(rand_word());
    wait_drained();
    // Larger grids with the window at full height and at one.
    run_grids(24, 24, 1);
    run_grids(12, 1, 1);
    // Random phases, mostly small grids; the first stretch runs without idling.
    sent = 0;
    while (sent < 420) begin
      int r, w, g;
      r = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
      w = ($urandom_range(6) == 0) ? $urandom_range(127) : $urandom_range(r, 1);
      g = $urandom_range(3, 1);
      calm = (sent < 150);
      run_grids(r, w, g);
      sent += g * r * (r + 1) / 2;
    end
    calm = 1'b0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (failures == 0 && expected_sums.size() == 0) begin
      $display("** triangle_window_max_sum: PASSED **");
    end else begin
      $display("** triangle_window_max_sum: FAILED **");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("** triangle_window_max_sum: FAILED **");
    $finish;
  end

endmodule
